// ===== sv/baro_pressure_temp_compensation_unit_defines.svh =====
// Assertion macros for the barometer compensation unit
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define BPTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bptc_pkg.sv =====
// Shared constants and types for the barometer compensation unit
`default_nettype none
package bptc_pkg;
	localparam int RAW_W   = 24;
	localparam int PQ_W    = 24;
	localparam int TQ_W    = 24;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 64;
	localparam int TCAL_W  = 40;
	localparam int SCAL_W  = 48;
	localparam int OCAL_W  = 48;
	localparam int QCAL_W  = 32;
	localparam int SUM_W   = 112;
	localparam int PSHIFT  = 79;

	localparam logic signed [SUM_W-1:0] P_ROUND = SUM_W'(1) <<< 78;
	localparam logic signed [60:0] T_ROUND = 61'sd2147483648;
	localparam logic signed [28:0] TQ_MAX = 29'sd8388607;
	localparam logic signed [28:0] TQ_MIN = -29'sd8388608;
	localparam logic [PQ_W-1:0] PQ_MAX = '1;
	localparam logic signed [16:0] SENS_BIAS = 17'sd16384;

	typedef enum logic [1:0] {
		REG_TEMP = 2'd0,
		REG_SENS = 2'd1,
		REG_OFFS = 2'd2,
		REG_QUAD = 2'd3
	} reg_idx_t;
endpackage
`default_nettype wire

// ===== sv/bptc_in_if.sv =====
// Sample channel: raw pressure and temperature words
`default_nettype none
interface bptc_in_if;
	logic valid;
	logic ready;
	logic [bptc_pkg::RAW_W-1:0] raw_pressure;
	logic [bptc_pkg::RAW_W-1:0] raw_temperature;
	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface
`default_nettype wire

// ===== sv/bptc_out_if.sv =====
// Result channel: compensated pressure and temperature words
`default_nettype none
interface bptc_out_if;
	logic valid;
	logic ready;
	logic [bptc_pkg::PQ_W-1:0] pressure_q6;
	logic signed [bptc_pkg::TQ_W-1:0] temperature_q16;
	modport source (output valid, output pressure_q6, output temperature_q16, input ready);
	modport sink (input valid, input pressure_q6, input temperature_q16, output ready);
endinterface
`default_nettype wire

// ===== sv/baro_pressure_temp_compensation_unit.sv =====
// Barometer pressure and temperature compensation, pipelined top level
// Pipeline: ten arithmetic stages plus the output register, sample to result word.
// Throughput: one sample per cycle; the whole pipe holds while a result word waits.
// Reset: async active low clears valid bits and calibration registers (all zero).
`default_nettype none
`include "baro_pressure_temp_compensation_unit_defines.svh"
module baro_pressure_temp_compensation_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	bptc_in_if.sink samples,
	bptc_out_if.source results,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [bptc_pkg::APB_AW-1:0] paddr,
	input  wire logic [bptc_pkg::APB_DW-1:0] pwdata,
	output logic [bptc_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	localparam int SW = bptc_pkg::SUM_W;

	logic [bptc_pkg::TCAL_W-1:0] tcal_q;
	logic [bptc_pkg::SCAL_W-1:0] scal_q;
	logic [bptc_pkg::OCAL_W-1:0] ocal_q;
	logic [bptc_pkg::QCAL_W-1:0] qcal_q;
	bptc_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx = bptc_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			scal_q <= '0;
			ocal_q <= '0;
			qcal_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				bptc_pkg::REG_TEMP: tcal_q <= pwdata[bptc_pkg::TCAL_W-1:0];
				bptc_pkg::REG_SENS: scal_q <= pwdata[bptc_pkg::SCAL_W-1:0];
				bptc_pkg::REG_OFFS: ocal_q <= pwdata[bptc_pkg::OCAL_W-1:0];
				bptc_pkg::REG_QUAD: qcal_q <= pwdata[bptc_pkg::QCAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			bptc_pkg::REG_TEMP: prdata = bptc_pkg::APB_DW'(tcal_q);
			bptc_pkg::REG_SENS: prdata = bptc_pkg::APB_DW'(scal_q);
			bptc_pkg::REG_OFFS: prdata = bptc_pkg::APB_DW'(ocal_q);
			bptc_pkg::REG_QUAD: prdata = bptc_pkg::APB_DW'(qcal_q);
			default: prdata = '0;
		endcase
	end

	// calibration coefficients, to be kept static by the user while samples flow; not enforced here
	logic [15:0] t1;
	logic signed [16:0] t2s, c1s, c2s, c5s, c6s;
	logic signed [7:0] t3s, c3s, c4s, c7s, c8s, c10s, c11s;
	logic signed [15:0] c9s;

	assign t1   = tcal_q[15:0];
	assign t2s  = $signed({1'b0, tcal_q[31:16]});
	assign t3s  = $signed(tcal_q[39:32]);
	assign c1s  = 17'($signed(scal_q[15:0])) - bptc_pkg::SENS_BIAS;
	assign c2s  = 17'($signed(scal_q[31:16])) - bptc_pkg::SENS_BIAS;
	assign c3s  = $signed(scal_q[39:32]);
	assign c4s  = $signed(scal_q[47:40]);
	assign c5s  = $signed({1'b0, ocal_q[15:0]});
	assign c6s  = $signed({1'b0, ocal_q[31:16]});
	assign c7s  = $signed(ocal_q[39:32]);
	assign c8s  = $signed(ocal_q[47:40]);
	assign c9s  = $signed(qcal_q[15:0]);
	assign c10s = $signed(qcal_q[23:16]);
	assign c11s = $signed(qcal_q[31:24]);

	logic en;
	logic out_v_q;
	logic [bptc_pkg::PQ_W-1:0] pq_q;
	logic signed [bptc_pkg::TQ_W-1:0] tq_q;

	assign en = !out_v_q || results.ready;
	assign samples.ready = en;
	assign results.valid = out_v_q;
	assign results.pressure_q6 = pq_q;
	assign results.temperature_q16 = tq_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [23:0] pr_s1, pr_s2, pr_s3, pr_s4, pr_s5, pr_s6, pr_s7, pr_s8;
	logic signed [24:0] d_s1;
	logic signed [41:0] pa_s2, pa_s3;
	logic signed [49:0] pb_s2;
	logic signed [57:0] pm_s3;
	logic signed [23:0] tq_s4, tq_s5, tq_s6, tq_s7, tq_s8, tq_s9, tq_s10;
	logic signed [47:0] t2_s5;
	logic signed [40:0] c6t_s5, c6t_s6, c6t_s7, c2t_s5, c2t_s6, c2t_s7;
	logic signed [31:0] c10t_s5;
	logic [47:0] pp_s5;
	logic signed [71:0] t3_s6;
	logic signed [55:0] c7t2_s6, c7t2_s7, c3t2_s6, c3t2_s7;
	logic [71:0] ppp_s6;
	logic signed [32:0] cq_s6;
	logic signed [79:0] c8t3_s7, c4t3_s7;
	logic signed [80:0] p11_s7, p11_s8;
	logic signed [57:0] prcq_s7;
	logic signed [SW-1:0] a_s8, c_s9, sum_s10;
	logic signed [87:0] b_s8;
	logic signed [82:0] ppcq_s8;
	logic [67:0] pbl_s9;
	logic signed [68:0] pbh_s9;

	logic signed [60:0] t48, trnd;
	logic signed [28:0] tr;
	logic signed [23:0] tq_c;

	assign t48  = (61'(pa_s3) <<< 18) + 61'(pm_s3);
	assign trnd = t48 + bptc_pkg::T_ROUND;
	assign tr   = trnd[60:32];

	always_comb begin
		if (tr > bptc_pkg::TQ_MAX) begin
			tq_c = bptc_pkg::TQ_MAX[23:0];
		end else if (tr < bptc_pkg::TQ_MIN) begin
			tq_c = bptc_pkg::TQ_MIN[23:0];
		end else begin
			tq_c = tr[23:0];
		end
	end

	logic [32:0] pint;
	logic [bptc_pkg::PQ_W-1:0] pq_c;
	assign pint = sum_s10[SW-1:bptc_pkg::PSHIFT];

	always_comb begin
		if (sum_s10[SW-1]) begin
			pq_c = '0;
		end else if (pint[32:24] != '0) begin
			pq_c = bptc_pkg::PQ_MAX;
		end else begin
			pq_c = pint[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
			out_v_q <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature
			pr_s1   <= samples.raw_pressure;
			d_s1    <= $signed({1'b0, samples.raw_temperature}) - $signed({1'b0, t1, 8'h00});
			pr_s2   <= pr_s1;
			pa_s2   <= 42'(d_s1) * 42'(t2s);
			pb_s2   <= 50'(d_s1) * 50'(d_s1);
			pr_s3   <= pr_s2;
			pa_s3   <= pa_s2;
			pm_s3   <= 58'(pb_s2) * 58'(t3s);
			pr_s4   <= pr_s3;
			tq_s4   <= tq_c;
			// powers of T and raw pressure
			pr_s5   <= pr_s4;
			tq_s5   <= tq_s4;
			t2_s5   <= 48'(tq_s4) * 48'(tq_s4);
			c6t_s5  <= 41'(c6s) * 41'(tq_s4);
			c2t_s5  <= 41'(c2s) * 41'(tq_s4);
			c10t_s5 <= 32'(c10s) * 32'(tq_s4);
			pp_s5   <= 48'(pr_s4) * 48'(pr_s4);
			pr_s6   <= pr_s5;
			tq_s6   <= tq_s5;
			t3_s6   <= 72'(t2_s5) * 72'(tq_s5);
			c7t2_s6 <= 56'(c7s) * 56'(t2_s5);
			c3t2_s6 <= 56'(c3s) * 56'(t2_s5);
			ppp_s6  <= 72'(pp_s5) * 72'(pr_s5);
			cq_s6   <= (33'(c9s) <<< 16) + 33'(c10t_s5);
			c6t_s6  <= c6t_s5;
			c2t_s6  <= c2t_s5;
			// cubic terms
			pr_s7   <= pr_s6;
			tq_s7   <= tq_s6;
			c8t3_s7 <= 80'(c8s) * 80'(t3_s6);
			c4t3_s7 <= 80'(c4s) * 80'(t3_s6);
			p11_s7  <= 81'($signed({1'b0, ppp_s6})) * 81'(c11s);
			prcq_s7 <= 58'($signed({1'b0, pr_s6})) * 58'(cq_s6);
			c6t_s7  <= c6t_s6;
			c2t_s7  <= c2t_s6;
			c7t2_s7 <= c7t2_s6;
			c3t2_s7 <= c3t2_s6;
			// offset and sensitivity polynomials
			pr_s8   <= pr_s7;
			tq_s8   <= tq_s7;
			a_s8    <= (SW'(c5s) <<< 88) + (SW'(c6t_s7) <<< 63)
				+ (SW'(c7t2_s7) <<< 45) + (SW'(c8t3_s7) <<< 22);
			b_s8    <= (88'(c1s) <<< 65) + (88'(c2t_s7) <<< 40)
				+ (88'(c3t2_s7) <<< 21) + 88'(c4t3_s7);
			ppcq_s8 <= 83'(prcq_s7) * 83'($signed({1'b0, pr_s7}));
			p11_s8  <= p11_s7;
			// pr * sensitivity in two halves
			tq_s9   <= tq_s8;
			pbl_s9  <= 68'(b_s8[43:0]) * 68'(pr_s8);
			pbh_s9  <= 69'($signed(b_s8[87:44])) * 69'($signed({1'b0, pr_s8}));
			c_s9    <= a_s8 + (SW'(ppcq_s8) <<< 21) + (SW'(p11_s8) <<< 20);
			// final sum with rounding
			tq_s10  <= tq_s9;
			sum_s10 <= c_s9 + (SW'(pbh_s9) <<< 44) + SW'($signed({1'b0, pbl_s9}))
				+ bptc_pkg::P_ROUND;
			// output word
			pq_q    <= pq_c;
			tq_q    <= tq_s10;
		end
	end

	`BPTC_ASSERT_NOW(a_stall_only_full, !en, out_v_q, "pipe held with no word waiting")
	`BPTC_ASSERT_NXT(a_neg_press_zero, en && v_s10 && sum_s10[SW-1], results.pressure_q6 == '0, "negative pressure not clamped to zero")
	`BPTC_ASSERT_NXT(a_stall_holds, !en && v_s5, v_s5 && $stable(tq_s5), "stage five changed during stall")
endmodule
`default_nettype wire

// ===== tb/tb_baro_pressure_temp_compensation_unit.sv =====
// Self-checking testbench for the barometer compensation unit
`timescale 1ns / 1ps
`default_nettype none
module tb_baro_pressure_temp_compensation_unit;
	localparam int LATENCY = 11;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [bptc_pkg::PQ_W-1:0] pressure;
		logic [bptc_pkg::TQ_W-1:0] temperature;
	} comp_word_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [bptc_pkg::APB_AW-1:0] paddr;
	logic [bptc_pkg::APB_DW-1:0] pwdata;
	logic [bptc_pkg::APB_DW-1:0] prdata;
	logic pready;

	bptc_in_if samples_if();
	bptc_out_if results_if();

	baro_pressure_temp_compensation_unit dut (
		.clk(clk), .arst_n(arst_n),
		.samples(samples_if), .results(results_if),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic [bptc_pkg::TCAL_W-1:0] temp_cal;
	logic [bptc_pkg::SCAL_W-1:0] sens_cal;
	logic [bptc_pkg::OCAL_W-1:0] offs_cal;
	logic [bptc_pkg::QCAL_W-1:0] quad_cal;

	comp_word_t pending_words[$];
	int mismatches;
	int snd_idle, rcv_idle;
	int hold_cycles;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic comp_word_t compensate(logic [bptc_pkg::RAW_W-1:0] pr,
			logic [bptc_pkg::RAW_W-1:0] rt);
		longint t1, t2, t3, d, t48, tq;
		logic signed [127:0] p, t, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, s;
		comp_word_t w;
		t1 = longint'(temp_cal[15:0]);
		t2 = longint'(temp_cal[31:16]);
		t3 = longint'($signed(temp_cal[39:32]));
		d = longint'(rt) - t1 * 256;
		t48 = d * t2 * 262144 + d * d * t3;
		tq = (t48 + 64'sd2147483648) >>> 32;
		if (tq > 8388607) tq = 8388607;
		if (tq < -8388608) tq = -8388608;
		p = 128'(pr);
		t = 128'(tq);
		c1 = 128'(longint'($signed(sens_cal[15:0])) - 16384);
		c2 = 128'(longint'($signed(sens_cal[31:16])) - 16384);
		c3 = 128'(longint'($signed(sens_cal[39:32])));
		c4 = 128'(longint'($signed(sens_cal[47:40])));
		c5 = 128'(longint'(offs_cal[15:0]));
		c6 = 128'(longint'(offs_cal[31:16]));
		c7 = 128'(longint'($signed(offs_cal[39:32])));
		c8 = 128'(longint'($signed(offs_cal[47:40])));
		c9 = 128'(longint'($signed(quad_cal[15:0])));
		c10 = 128'(longint'($signed(quad_cal[23:16])));
		c11 = 128'(longint'($signed(quad_cal[31:24])));
		s = (c5 <<< 88) + ((c6 * t) <<< 63) + ((c7 * t * t) <<< 45)
			+ ((c8 * t * t * t) <<< 22) + ((p * c1) <<< 65) + ((p * c2 * t) <<< 40)
			+ ((p * c3 * t * t) <<< 21) + p * c4 * t * t * t + ((p * p * c9) <<< 37)
			+ ((p * p * c10 * t) <<< 21) + ((p * p * p * c11) <<< 20)
			+ (128'sd1 <<< 78);
		if (s[127])
			w.pressure = '0;
		else if (s[126:103] != '0)
			w.pressure = bptc_pkg::PQ_MAX;
		else
			w.pressure = s[102:79];
		w.temperature = tq[23:0];
		return w;
	endfunction

	// result side: stall pattern plus optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			results_if.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			results_if.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: p=%0d t=%0d", results_if.pressure_q6,
						results_if.temperature_q16);
			end else begin
				comp_word_t exp_w;
				exp_w = pending_words.pop_front();
				if (results_if.pressure_q6 !== exp_w.pressure ||
						results_if.temperature_q16 !== exp_w.temperature) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: p exp %0d got %0d, t exp %0d got %0d",
							exp_w.pressure, results_if.pressure_q6,
							$signed(exp_w.temperature), results_if.temperature_q16);
				end
			end
		end
	end

	task automatic send_sample(logic [bptc_pkg::RAW_W-1:0] pr, logic [bptc_pkg::RAW_W-1:0] rt);
		while ($urandom_range(99) < snd_idle) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.raw_pressure <= pr;
		samples_if.raw_temperature <= rt;
		do @(posedge clk); while (!samples_if.ready);
		pending_words.push_back(compensate(pr, rt));
		@(negedge clk);
	endtask

	task automatic drain();
		samples_if.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(bptc_pkg::reg_idx_t idx, logic [bptc_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= bptc_pkg::APB_AW'(idx) << 3;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			bptc_pkg::REG_TEMP: temp_cal = value[bptc_pkg::TCAL_W-1:0];
			bptc_pkg::REG_SENS: sens_cal = value[bptc_pkg::SCAL_W-1:0];
			bptc_pkg::REG_OFFS: offs_cal = value[bptc_pkg::OCAL_W-1:0];
			bptc_pkg::REG_QUAD: quad_cal = value[bptc_pkg::QCAL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_cal(logic [63:0] tc, logic [63:0] sc, logic [63:0] oc, logic [63:0] qc);
		write_reg(bptc_pkg::REG_TEMP, tc);
		write_reg(bptc_pkg::REG_SENS, sc);
		write_reg(bptc_pkg::REG_OFFS, oc);
		write_reg(bptc_pkg::REG_QUAD, qc);
	endtask

	// typical factory calibration set
	task automatic load_typical_cal();
		load_cal({24'd0, 8'hF9, 16'd19000, 16'd27800},
			{16'd0, 8'd2, 8'd40, 16'hF830, 16'hFF38},
			{16'd0, 8'hFA, 8'd3, 16'd30000, 16'd26000},
			{32'd0, 8'hD8, 8'd4, 16'd15000});
	endtask

	task automatic load_random_cal();
		load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom});
	endtask

	task automatic send_corners();
		send_sample(24'd0, 24'd0);
		send_sample('1, '1);
		send_sample('1, 24'd0);
		send_sample(24'd0, '1);
		send_sample(24'h800000, 24'h800000);
	endtask

	task automatic send_mixed();
		if ($urandom_range(99) < 65)
			send_sample(bptc_pkg::RAW_W'($urandom_range(8000000, 5000000)),
				bptc_pkg::RAW_W'($urandom_range(9000000, 7500000)));
		else
			send_sample(bptc_pkg::RAW_W'($urandom), bptc_pkg::RAW_W'($urandom));
	endtask

	task automatic test_reset_values();
		send_corners();
		drain();
	endtask

	task automatic test_directed();
		load_typical_cal();
		send_corners();
		send_sample(24'd6500000, 24'd8400000);
		send_sample(24'd7200000, 24'd8600000);
		drain();
		load_cal('1, '1, '1, '1);
		send_corners();
		drain();
		load_cal({24'd0, 8'h7F, 16'hFFFF, 16'd0}, {16'd0, 8'h80, 8'h7F, 16'h8000, 16'h7FFF},
			{16'd0, 8'h7F, 8'h80, 16'hFFFF, 16'hFFFF}, {32'd0, 8'h7F, 8'h80, 16'h7FFF});
		send_corners();
		drain();
	endtask

	task automatic test_random_stream(int n, int s_idle, int r_idle);
		snd_idle = s_idle;
		rcv_idle = r_idle;
		for (int i = 0; i < n; i++) begin
			if (i % 150 == 0) begin
				drain();
				if ($urandom_range(99) < 60) load_typical_cal();
				else load_random_cal();
			end
			send_mixed();
		end
		drain();
	endtask

	task automatic test_backpressure();
		snd_idle = 0;
		rcv_idle = 0;
		load_typical_cal();
		hold_cycles = 300;
		for (int i = 0; i < 60; i++) send_mixed();
		drain();
		for (int i = 0; i < 40; i++) send_mixed();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.raw_pressure = '0;
		samples_if.raw_temperature = '0;
		results_if.ready = 1'b0;
		temp_cal = '0;
		sens_cal = '0;
		offs_cal = '0;
		quad_cal = '0;
		mismatches = 0;
		snd_idle = 0;
		rcv_idle = 0;
		hold_cycles = 0;
		cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_values();
		test_directed();
		test_random_stream(600, 17, 47);
		test_random_stream(600, 47, 17);
		test_random_stream(600, 0, 0);
		test_backpressure();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/bptc_pkg.sv
sv/bptc_in_if.sv
sv/bptc_out_if.sv
sv/baro_pressure_temp_compensation_unit.sv
tb/tb_baro_pressure_temp_compensation_unit.sv
